@@ design/ckt_pkg.sv @@
// Shared types and constants for the counting key table.
`default_nettype none

package ckt_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = 8;
    localparam int IN_KEY_W  = 32;
    localparam int SLOT_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_RAISED    = 3'd0,
        ST_ALLOCATED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_LOWERED   = 3'd3,
        ST_FREED     = 3'd4,
        ST_MISS      = 3'd5
    } status_t;

    // Search token handed from cell to cell, gathering the first match and
    // the first free entry along the way.
    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic [KEY_WIDTH-1:0] key;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [CNT_W-1:0]     hit_cnt;
        logic                 free;
        logic [IDX_W-1:0]     free_idx;
    } token_t;

    // Update broadcast to all cells; only the addressed cell takes it.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [KEY_WIDTH-1:0] key;
        logic [CNT_W-1:0]     cnt;
    } wr_t;

endpackage

`default_nettype wire

@@ design/counting_key_table_unit.sv @@
// Top level of the counting key table: cell chain, sequencer and result register.
`default_nettype none

// Channel  Handshake          Payload
// s_       s_valid, s_ready   s_kind (0 add, 1 remove), s_key
// m_       m_valid, m_ready   m_status, m_slot, m_count
//
// Between one input transfer and the next, the search token walks the chain of
// cells one entry per cycle, the hold register parks it, and the update is then
// applied and the result register loaded, after which s_ready is high again.
// Reset is synchronous and active low; it clears every entry's key and count at
// once. A result waiting on m_ready does not block the next transfer on s_, but a
// finished search waits in its hold state until the result register is free.

module counting_key_table_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [ckt_pkg::IN_KEY_W-1:0]    s_key,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_status,
    output logic [ckt_pkg::SLOT_W-1:0]           m_slot,
    output logic [ckt_pkg::CNT_W-1:0]            m_count
);

    localparam int N  = ckt_pkg::ENTRIES;
    localparam int KW = ckt_pkg::KEY_WIDTH;
    localparam int IW = ckt_pkg::IDX_W;
    localparam int CW = ckt_pkg::CNT_W;
    localparam int SW = ckt_pkg::SLOT_W;

    // One-hot sequencer: waiting for an item, search in flight, search done.
    typedef enum logic [2:0] {
        S_WAIT = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    ckt_pkg::token_t tok_chain [N+1];
    ckt_pkg::token_t fin_reg;
    ckt_pkg::wr_t    wr;

    ckt_pkg::status_t  status_reg;
    ckt_pkg::status_t  status_next;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_valid_reg;

    logic accept_in;
    logic out_free;
    logic retire;
    logic [CW-1:0] lowered;

    assign s_ready   = (state_reg == S_WAIT);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign retire    = (state_reg == S_HOLD) && out_free;

    // The token enters cell 0 in the cycle of the input transfer.
    always_comb begin
        tok_chain[0]          = '0;
        tok_chain[0].valid    = accept_in;
        tok_chain[0].kind     = ckt_pkg::kind_t'(s_kind);
        tok_chain[0].key      = KW'(s_key);
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        ckt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IW'(i)),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .wr       (wr)
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_WAIT: begin
                if (accept_in) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (tok_chain[N].valid) state_next = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) state_next = S_WAIT;
            end
            default: state_next = S_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // The finished token is held here until the result register can take it.
    always_ff @(posedge aclk) begin
        if (tok_chain[N].valid) begin
            fin_reg <= tok_chain[N];
        end
    end

    assign lowered = fin_reg.hit_cnt - CW'(1);

    // Decide the update and the result from the gathered search outcome.
    always_comb begin
        wr          = '0;
        wr.key      = fin_reg.key;
        status_next = ckt_pkg::ST_DROPPED;
        slot_next   = '0;
        count_next  = '0;
        if (fin_reg.kind == ckt_pkg::KIND_ADD) begin
            if (fin_reg.hit) begin
                wr.en       = retire;
                wr.idx      = fin_reg.hit_idx;
                wr.cnt      = (fin_reg.hit_cnt == ckt_pkg::CNT_MAX) ?
                              ckt_pkg::CNT_MAX : fin_reg.hit_cnt + CW'(1);
                status_next = ckt_pkg::ST_RAISED;
                slot_next   = SW'(fin_reg.hit_idx);
                count_next  = wr.cnt;
            end else if (fin_reg.free) begin
                wr.en       = retire;
                wr.idx      = fin_reg.free_idx;
                wr.cnt      = CW'(1);
                status_next = ckt_pkg::ST_ALLOCATED;
                slot_next   = SW'(fin_reg.free_idx);
                count_next  = CW'(1);
            end else begin
                status_next = ckt_pkg::ST_DROPPED;
            end
        end else begin
            if (fin_reg.hit) begin
                wr.en       = retire;
                wr.idx      = fin_reg.hit_idx;
                wr.cnt      = lowered;
                slot_next   = SW'(fin_reg.hit_idx);
                count_next  = lowered;
                if (lowered == '0) begin
                    // A freed entry gets its key cleared as well.
                    wr.key      = '0;
                    status_next = ckt_pkg::ST_FREED;
                end else begin
                    status_next = ckt_pkg::ST_LOWERED;
                end
            end else begin
                status_next = ckt_pkg::ST_MISS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_slot   = slot_reg;
    assign m_count  = count_reg;

endmodule

`default_nettype wire

@@ design/ckt_cell.sv @@
// One table entry: stored key and count, plus one stage of the search token.
`default_nettype none

module ckt_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [ckt_pkg::IDX_W-1:0]    cell_idx,
    input  wire ckt_pkg::token_t              tok_in,
    output ckt_pkg::token_t                   tok_out,
    input  wire ckt_pkg::wr_t                 wr
);

    logic [ckt_pkg::KEY_WIDTH-1:0] key_reg;
    logic [ckt_pkg::CNT_W-1:0]     cnt_reg;
    ckt_pkg::token_t               tok_reg;
    ckt_pkg::token_t               tok_next;
    logic                          occupied;
    logic                          match;

    assign occupied = (cnt_reg != '0);
    assign match    = occupied && (key_reg == tok_in.key);

    always_comb begin
        tok_next = tok_in;
        if (!tok_in.hit && match) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
            tok_next.hit_cnt = cnt_reg;
        end
        if (!tok_in.free && !occupied) begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            cnt_reg <= '0;
        end else if (wr.en && (wr.idx == cell_idx)) begin
            key_reg <= wr.key;
            cnt_reg <= wr.cnt;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ test/tb_counting_key_table_unit.sv @@
// Self-checking testbench for counting_key_table_unit: directed and random add/remove traffic.
`timescale 1ns / 1ps

module tb_counting_key_table_unit;

    // One pending input transfer: what to do and with which key.
    typedef struct {
        ckt_pkg::kind_t                kind;
        logic [ckt_pkg::IN_KEY_W-1:0]  key;
    } table_op_t;

    // What the block should report for one operation.
    typedef struct {
        ckt_pkg::status_t              status;
        logic [ckt_pkg::SLOT_W-1:0]    slot;
        logic [ckt_pkg::CNT_W-1:0]     count;
    } tally_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_valid  = 1'b0;
    logic                            s_ready;
    logic                            s_kind   = 1'b0;
    logic [ckt_pkg::IN_KEY_W-1:0]    s_key    = '0;
    logic                            m_valid;
    logic                            m_ready  = 1'b0;
    logic [2:0]                      m_status;
    logic [ckt_pkg::SLOT_W-1:0]      m_slot;
    logic [ckt_pkg::CNT_W-1:0]       m_count;

    // Shadow copy of the table, updated in transfer order.
    logic [ckt_pkg::KEY_WIDTH-1:0]   shadow_keys   [ckt_pkg::ENTRIES];
    logic [ckt_pkg::CNT_W-1:0]       shadow_counts [ckt_pkg::ENTRIES];

    table_op_t                       pending_ops[$];
    tally_t                          expected_tallies[$];
    logic [ckt_pkg::IN_KEY_W-1:0]    key_pool[24];

    int unsigned            send_gap_pct   = 0;
    int unsigned            recv_stall_pct = 0;
    int unsigned            mismatch_count = 0;
    bit                     op_taken       = 1'b0;

    counting_key_table_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_key    (s_key),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_slot   (m_slot),
        .m_count  (m_count)
    );

    // 10 ns clock period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Applies one operation to the shadow table and returns the result the block
    // must produce. Only occupied entries (nonzero count) can match, so key zero
    // behaves like any other key and a free entry is never mistaken for a hit.
    function automatic tally_t predict_table_step(ckt_pkg::kind_t kind,
                                                  logic [ckt_pkg::IN_KEY_W-1:0] raw_key);
        logic [ckt_pkg::KEY_WIDTH-1:0] k;
        int                   hit;
        int                   spare;
        tally_t               t;
        k     = ckt_pkg::KEY_WIDTH'(raw_key);
        hit   = -1;
        spare = -1;
        for (int i = 0; i < ckt_pkg::ENTRIES; i++) begin
            if (hit < 0 && shadow_counts[i] != '0 && shadow_keys[i] == k)
                hit = i;
            if (spare < 0 && shadow_counts[i] == '0)
                spare = i;
        end
        t.slot  = '0;
        t.count = '0;
        if (kind == ckt_pkg::KIND_ADD) begin
            if (hit >= 0) begin
                // The count sticks at its maximum instead of wrapping to zero.
                if (shadow_counts[hit] != ckt_pkg::CNT_MAX)
                    shadow_counts[hit] = shadow_counts[hit] + 1'b1;
                t.status = ckt_pkg::ST_RAISED;
                t.slot   = ckt_pkg::SLOT_W'(hit);
                t.count  = shadow_counts[hit];
            end else if (spare >= 0) begin
                shadow_keys[spare]   = k;
                shadow_counts[spare] = ckt_pkg::CNT_W'(1);
                t.status = ckt_pkg::ST_ALLOCATED;
                t.slot   = ckt_pkg::SLOT_W'(spare);
                t.count  = ckt_pkg::CNT_W'(1);
            end else begin
                // No match and no free entry: the add is dropped, table unchanged.
                t.status = ckt_pkg::ST_DROPPED;
            end
        end else begin
            if (hit >= 0) begin
                shadow_counts[hit] = shadow_counts[hit] - 1'b1;
                if (shadow_counts[hit] == '0) begin
                    shadow_keys[hit] = '0;
                    t.status = ckt_pkg::ST_FREED;
                end else begin
                    t.status = ckt_pkg::ST_LOWERED;
                end
                t.slot  = ckt_pkg::SLOT_W'(hit);
                t.count = shadow_counts[hit];
            end else begin
                t.status = ckt_pkg::ST_MISS;
            end
        end
        return t;
    endfunction

    function automatic void queue_op(ckt_pkg::kind_t kind,
                                     logic [ckt_pkg::IN_KEY_W-1:0] key);
        table_op_t op;
        op.kind = kind;
        op.key  = key;
        pending_ops.push_back(op);
    endfunction

    // Builds one phase of random traffic. Most of it is drawn from a small pool
    // of keys so that hits, frees, a full table and drops happen often; the rest
    // is noise with fully random keys or keys one bit away from a pool key.
    function automatic void queue_random_phase(int unsigned n_ops);
        int unsigned queued;
        int unsigned pick;
        int unsigned run_len;
        logic [ckt_pkg::IN_KEY_W-1:0] k;
        queued = 0;
        while (queued < n_ops) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // Churn: mixed adds and removes on pool keys, leaning toward adds.
                run_len = $urandom_range(8, 24);
                repeat (run_len) begin
                    k = key_pool[$urandom_range(0, 23)];
                    queue_op(($urandom_range(0, 99) < 55) ?
                             ckt_pkg::KIND_ADD : ckt_pkg::KIND_REMOVE, k);
                end
            end else if (pick < 65) begin
                // Fill burst: the pool is larger than the table, so this can overflow it.
                run_len = $urandom_range(10, 20);
                repeat (run_len) queue_op(ckt_pkg::KIND_ADD, key_pool[$urandom_range(0, 23)]);
            end else if (pick < 85) begin
                // Drain: removes on pool keys, freeing entries and causing misses.
                run_len = $urandom_range(10, 24);
                repeat (run_len)
                    queue_op(ckt_pkg::KIND_REMOVE, key_pool[$urandom_range(0, 23)]);
            end else begin
                run_len = $urandom_range(1, 6);
                repeat (run_len) begin
                    if ($urandom_range(0, 1) == 0)
                        k = $urandom();
                    else
                        k = key_pool[$urandom_range(0, 23)] ^
                            (ckt_pkg::IN_KEY_W'(1) <<
                             $urandom_range(0, ckt_pkg::IN_KEY_W - 1));
                    queue_op(ckt_pkg::kind_t'($urandom_range(0, 1)), k);
                end
            end
            queued += run_len;
        end
    endfunction

    // Record each input transfer and predict its result right away, so the
    // expectations stay in the order in which the block saw the operations.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_tallies.push_back(predict_table_step(ckt_pkg::kind_t'(s_kind), s_key));
            op_taken = 1'b1;
        end
    end

    // Driver: inputs change on the falling edge. A new item is only presented
    // once the previous one has been transferred; the gap decision is taken
    // only while valid is low or just after a transfer, so a presented item is never withdrawn.
    always @(negedge aclk) begin
        table_op_t op;
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || op_taken) begin
            op_taken = 1'b0;
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                op = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_kind  <= op.kind;
                s_key   <= op.key;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: every result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        tally_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tallies.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d count=%0d",
                                          m_status, m_slot, m_count));
            end else begin
                want = expected_tallies.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                if (m_slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d (status %0d)",
                                              m_slot, want.slot, want.status));
                if (m_count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d (status %0d)",
                                              m_count, want.count, want.status));
            end
        end
    end

    // Watchdog. The slowest correct run is well under a millisecond, so five
    // milliseconds only trips on a hang.
    initial begin
        #5ms;
        $display("** counting_key_table_unit: FAILED **");
        $finish;
    end

    task automatic wait_until_drained();
        while (pending_ops.size() != 0 || s_valid || expected_tallies.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        for (int i = 0; i < ckt_pkg::ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_counts[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 24; i++)
            key_pool[i] = $urandom();

        // The first phase stalls the sender 38% and the receiver 55% of cycles.
        send_gap_pct   = 38;
        recv_stall_pct = 55;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Key zero is an ordinary key: allocate, raise, lower,
        // free, then a remove of it misses because the freed entry is empty.
        queue_op(ckt_pkg::KIND_ADD,    32'h0000_0000);
        queue_op(ckt_pkg::KIND_ADD,    32'h0000_0000);
        queue_op(ckt_pkg::KIND_REMOVE, 32'h0000_0000);
        queue_op(ckt_pkg::KIND_REMOVE, 32'h0000_0000);
        queue_op(ckt_pkg::KIND_REMOVE, 32'h0000_0000);
        // Fill every entry: the all-ones key, key zero, and fourteen one-hot keys.
        queue_op(ckt_pkg::KIND_ADD,    32'hFFFF_FFFF);
        queue_op(ckt_pkg::KIND_ADD,    32'h0000_0000);
        for (int i = 0; i < ckt_pkg::ENTRIES - 2; i++)
            queue_op(ckt_pkg::KIND_ADD, 32'h0000_0001 << i);
        // Table is full now, so a new key is dropped.
        queue_op(ckt_pkg::KIND_ADD,    32'h8000_0000);
        // Freeing the first entry lets the dropped key in at slot zero.
        queue_op(ckt_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
        queue_op(ckt_pkg::KIND_ADD,    32'h8000_0000);

        // Saturation: key one already sits in the table, so enough adds of it
        // pin its count at the maximum, then removes lower it from there.
        repeat (int'(ckt_pkg::CNT_MAX) + 3) queue_op(ckt_pkg::KIND_ADD, 32'h0000_0001);
        repeat (3) queue_op(ckt_pkg::KIND_REMOVE, 32'h0000_0001);

        queue_random_phase(330);

        wait_until_drained();

        // Second phase: the stall rates swap sides.
        @(posedge aclk);
        send_gap_pct   = 55;
        recv_stall_pct = 38;
        queue_random_phase(470);
        wait_until_drained();

        // Last phase: both sides run at full speed.
        @(posedge aclk);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        queue_random_phase(470);
        wait_until_drained();

        // A few search lengths more, to catch any stray result.
        repeat (2 * ckt_pkg::ENTRIES + 8) @(posedge aclk);

        if (mismatch_count == 0 && expected_tallies.size() == 0)
            $display("** counting_key_table_unit: PASSED **");
        else
            $display("** counting_key_table_unit: FAILED **");
        $finish;
    end

endmodule
